// ===== design/sorb_pkg.sv =====
// ----------------------------------------------------------------------------
// sorb_pkg
// Shared types and codes for the sequence reorder buffer.
// ----------------------------------------------------------------------------
package sorb_pkg;

  localparam logic [2:0] KIND_DELIVERED = 3'd0;
  localparam logic [2:0] KIND_BUFFERED  = 3'd1;
  localparam logic [2:0] KIND_DROP_OLD  = 3'd2;
  localparam logic [2:0] KIND_DROP_DUP  = 3'd3;
  localparam logic [2:0] KIND_DROP_FULL = 3'd4;

  typedef struct packed {
    logic [63:0] seq;
    logic [31:0] payload_handle;
    logic [15:0] payload_length;
  } sorb_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] out_seq;
    logic [31:0] out_handle;
    logic [15:0] out_length;
    logic        last;
    logic [63:0] ack_value;
    logic [5:0]  held_count;
  } sorb_out_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic act;
    logic pop;
  } sorb_cmd_t;

  typedef struct packed {
    logic out_free;
    logic hit;
    logic more_first;
    logic more_pop;
  } sorb_sts_t;

endpackage

// ===== design/sorb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sorb_ctrl
// Controller: sequences compare, action and drain of the reorder store.
// ----------------------------------------------------------------------------
module sorb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sorb_pkg::sorb_sts_t sts,
  output sorb_pkg::sorb_cmd_t cmd
);
  import sorb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CMP   = 4'b0010,
    ST_ACT   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.cmp  = (state_r == ST_CMP);
    cmd.act  = (state_r == ST_ACT) && sts.out_free;
    cmd.pop  = (state_r == ST_DRAIN) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CMP;
      end
      ST_CMP: state_nxt = ST_ACT;
      ST_ACT: begin
        if (sts.out_free) state_nxt = (sts.hit && sts.more_first) ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (sts.out_free && !sts.more_pop) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== design/sorb_dp.sv =====
// ----------------------------------------------------------------------------
// sorb_dp
// Datapath: sorted shift store, per-cell compares and output register.
// ----------------------------------------------------------------------------
module sorb_dp #(
  parameter int REORDER_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sorb_pkg::sorb_in_t  in_data,
  input  sorb_pkg::sorb_cmd_t cmd,
  output sorb_pkg::sorb_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output sorb_pkg::sorb_out_t out_data
);
  import sorb_pkg::*;

  localparam int N = REORDER_SLOTS;

  sorb_in_t            in_r;
  logic [63:0]         ne_r;
  logic [5:0]          cnt_r;
  logic [63:0]         sseq_r [N];
  logic [31:0]         shdl_r [N];
  logic [15:0]         slen_r [N];
  logic [N-1:0]        gt_r, eq_r, vld;
  logic                old_r, hit_r;
  sorb_out_t           out_r;
  logic                out_valid_r;

  logic                full, dup, ins;
  logic [63:0]         ne_inc;
  logic [63:0]         head1;

  assign ne_inc = ne_r + 64'd1;
  assign full   = cnt_r >= 6'(N);
  assign dup    = |(eq_r & vld);
  assign ins    = !old_r && !hit_r && !full && !dup;

  generate
    if (N > 1) begin : g_h1
      assign head1 = sseq_r[1];
    end else begin : g_h1n
      assign head1 = '0;
    end
  endgenerate

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.hit        = hit_r;
  assign sts.more_first = (cnt_r != 6'd0) && (sseq_r[0] == in_r.seq + 64'd1);
  assign sts.more_pop   = (cnt_r > 6'd1) && (head1 == sseq_r[0] + 64'd1);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.cmp) begin
      old_r <= in_r.seq < ne_r;
      hit_r <= in_r.seq == ne_r;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic prev_gt, shifted;
      assign vld[gi]  = cnt_r > 6'(gi);
      assign prev_gt  = (gi > 0) ? gt_r[(gi > 0) ? gi-1 : 0] : 1'b0;
      assign shifted  = (vld[gi] && gt_r[gi]) || (cnt_r == 6'(gi));

      always_ff @(posedge clk) begin
        if (cmd.cmp) begin
          gt_r[gi] <= sseq_r[gi] > in_r.seq;
          eq_r[gi] <= sseq_r[gi] == in_r.seq;
        end
        if (cmd.act && ins && shifted) begin
          if (prev_gt) begin
            sseq_r[gi] <= sseq_r[(gi > 0) ? gi-1 : 0];
            shdl_r[gi] <= shdl_r[(gi > 0) ? gi-1 : 0];
            slen_r[gi] <= slen_r[(gi > 0) ? gi-1 : 0];
          end else begin
            sseq_r[gi] <= in_r.seq;
            shdl_r[gi] <= in_r.payload_handle;
            slen_r[gi] <= in_r.payload_length;
          end
        end else if (cmd.pop && (gi < N-1)) begin
          sseq_r[gi] <= sseq_r[(gi < N-1) ? gi+1 : gi];
          shdl_r[gi] <= shdl_r[(gi < N-1) ? gi+1 : gi];
          slen_r[gi] <= slen_r[(gi < N-1) ? gi+1 : gi];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.act) begin
      out_r.out_seq    <= in_r.seq;
      out_r.out_handle <= in_r.payload_handle;
      out_r.out_length <= in_r.payload_length;
      out_r.last       <= 1'b1;
      out_r.ack_value  <= ne_r;
      out_r.held_count <= cnt_r;
      priority if (old_r) begin
        out_r.kind <= KIND_DROP_OLD;
      end else if (hit_r) begin
        out_r.kind      <= KIND_DELIVERED;
        out_r.last      <= !sts.more_first;
        out_r.ack_value <= ne_inc;
      end else if (full) begin
        out_r.kind <= KIND_DROP_FULL;
      end else if (dup) begin
        out_r.kind <= KIND_DROP_DUP;
      end else begin
        out_r.kind       <= KIND_BUFFERED;
        out_r.held_count <= cnt_r + 6'd1;
      end
    end else if (cmd.pop) begin
      out_r.kind       <= KIND_DELIVERED;
      out_r.out_seq    <= sseq_r[0];
      out_r.out_handle <= shdl_r[0];
      out_r.out_length <= slen_r[0];
      out_r.last       <= !sts.more_pop;
      out_r.ack_value  <= ne_inc;
      out_r.held_count <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.act || cmd.pop) out_valid_r <= 1'b1;
      else if (out_ready)     out_valid_r <= 1'b0;
      if (cmd.act && hit_r && !old_r) ne_r <= ne_inc;
      if (cmd.act && ins)             cnt_r <= cnt_r + 6'd1;
      if (cmd.pop) begin
        ne_r  <= ne_inc;
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

endmodule

// ===== design/sequence_reorder_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_unit
// The first result passes the load, compare and act steps in order; act waits for a free output.
// One input is taken at a time: in_ready returns only after act and the drain of any stored packets it releases;
// the single compare/act sequencer over the sorted shift store sets this.
// Reset: synchronous active-low rst_n clears next expected, count and valids;
// store contents are not cleared.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_unit #(
  parameter int REORDER_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sorb_pkg::sorb_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sorb_pkg::sorb_out_t out_data
);
  import sorb_pkg::*;

  sorb_cmd_t cmd;
  sorb_sts_t sts;

  sorb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sorb_dp #(.REORDER_SLOTS(REORDER_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/sorb_chk.sv =====
// ----------------------------------------------------------------------------
// sorb_chk
// Port-level checker for the sequence reorder buffer.
// ----------------------------------------------------------------------------
module sorb_chk #(
  parameter int REORDER_SLOTS = 32
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input sorb_pkg::sorb_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input sorb_pkg::sorb_out_t out_data
);
  import sorb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during active transaction");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_DELIVERED |-> out_data.last)
    else $error("non-delivery result without last");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.held_count <= 6'(REORDER_SLOTS))
    else $error("held count above store depth");

  a_buffered_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_BUFFERED |-> out_data.held_count != 6'd0)
    else $error("buffered with empty store");

endmodule

bind sequence_reorder_buffer_unit sorb_chk #(.REORDER_SLOTS(REORDER_SLOTS)) u_sorb_chk (.*);

// ===== bench/sequence_reorder_buffer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_unit_tb
// Drives packets with random gaps and random output stalls into the reorder
// buffer. Each accepted packet is run through an in-bench model of the sorted
// store to build the expected results, which are compared field by field
// with the block's outputs. A directed table opens the run; windowed random
// sequences, old, duplicate and full-store cases follow.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_unit_tb;
  import sorb_pkg::*;

  localparam int SLOTS = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  sorb_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  sorb_out_t out_data;

  sequence_reorder_buffer_unit #(.REORDER_SLOTS(SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // reorder store model
  logic [63:0] exp_next;
  int          held;
  sorb_in_t    held_pkt [SLOTS];
  sorb_out_t   pending_results [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;
  bit  long_hold = 0;
  int  hold_cycles = 0;

  typedef struct {
    sorb_in_t  pkt;
    bit        has_exp;
    sorb_out_t exp_res;
  } dir_row_t;
  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever begin
      #6 clk = 1'b1;
      #6 clk = 1'b0;
    end
  end

  function automatic sorb_out_t make_result(logic [2:0] k, sorb_in_t p, logic l);
    sorb_out_t r;
    r.kind       = k;
    r.out_seq    = p.seq;
    r.out_handle = p.payload_handle;
    r.out_length = p.payload_length;
    r.last       = l;
    r.ack_value  = exp_next;
    r.held_count = 6'(held);
    return r;
  endfunction

  task automatic predict_reorder(input sorb_in_t p);
    int pos;
    sorb_in_t h;
    pos = held;
    if (p.seq < exp_next) begin
      pending_results.push_back(make_result(KIND_DROP_OLD, p, 1'b1));
    end else if (p.seq == exp_next) begin
      exp_next++;
      pending_results.push_back(make_result(KIND_DELIVERED, p, 1'b0));
      while (held > 0 && held_pkt[0].seq == exp_next) begin
        h = held_pkt[0];
        for (int i = 1; i < held; i++) held_pkt[i-1] = held_pkt[i];
        held--;
        exp_next++;
        pending_results.push_back(make_result(KIND_DELIVERED, h, 1'b0));
      end
      pending_results[$].last = 1'b1;
    end else if (held >= SLOTS) begin
      pending_results.push_back(make_result(KIND_DROP_FULL, p, 1'b1));
    end else begin
      for (int i = 0; i < held; i++) begin
        if (held_pkt[i].seq == p.seq) begin
          pending_results.push_back(make_result(KIND_DROP_DUP, p, 1'b1));
          return;
        end
        if (held_pkt[i].seq > p.seq) begin
          pos = i;
          break;
        end
      end
      for (int i = held; i > pos; i--) held_pkt[i] = held_pkt[i-1];
      held_pkt[pos] = p;
      held++;
      pending_results.push_back(make_result(KIND_BUFFERED, p, 1'b1));
    end
  endtask

  function automatic sorb_in_t mk_pkt(logic [63:0] s);
    sorb_in_t p;
    p.seq = s;
    p.payload_handle = $urandom;
    p.payload_length = 16'($urandom);
    return p;
  endfunction

  task automatic add_row(sorb_in_t p, bit has_exp, sorb_out_t e);
    dir_row_t r;
    r.pkt = p;
    r.has_exp = has_exp;
    r.exp_res = e;
    dir_rows.push_back(r);
  endtask

  task automatic send_pkt(sorb_in_t p);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_reorder(p);
    @(negedge clk);
  endtask

  // directed rows whose expectation was already placed
  task automatic send_pkt_noexp(sorb_in_t p);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender
  initial begin
    sorb_in_t p;
    sorb_out_t e;
    sorb_out_t none;
    logic [63:0] base;
    int dice;
    none = '0;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    exp_next = '0;
    held     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    p = '{seq: 64'd5, payload_handle: 32'hFFFF_FFFF, payload_length: 16'hFFFF};
    e = '{kind: KIND_BUFFERED, out_seq: 64'd5, out_handle: 32'hFFFF_FFFF,
          out_length: 16'hFFFF, last: 1'b1, ack_value: 64'd0, held_count: 6'd1};
    add_row(p, 1, e);
    p = '{seq: 64'd5, payload_handle: 32'h0, payload_length: 16'h0};
    e = '{kind: KIND_DROP_DUP, out_seq: 64'd5, out_handle: 32'h0,
          out_length: 16'h0, last: 1'b1, ack_value: 64'd0, held_count: 6'd1};
    add_row(p, 1, e);
    p = '{seq: 64'hFFFF_FFFF_FFFF_FFFF, payload_handle: 32'h1, payload_length: 16'h1};
    add_row(p, 0, none);
    for (int s = 0; s < 5; s++) add_row(mk_pkt(64'(s)), 0, none);
    p = '{seq: 64'd2, payload_handle: 32'hA5A5_A5A5, payload_length: 16'h5A5A};
    e = '{kind: KIND_DROP_OLD, out_seq: 64'd2, out_handle: 32'hA5A5_A5A5,
          out_length: 16'h5A5A, last: 1'b1, ack_value: 64'd6, held_count: 6'd1};
    add_row(p, 1, e);
    for (int s = 8; s < 8 + SLOTS; s++) add_row(mk_pkt(64'(s)), 0, none);
    add_row(mk_pkt(64'd8), 0, none);
    add_row(mk_pkt(64'd100), 0, none);
    add_row(mk_pkt(64'd6), 0, none);
    add_row(mk_pkt(64'd7), 0, none);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        predict_reorder(dir_rows[i].pkt);
        e = pending_results.pop_back();
        pending_results.push_back(dir_rows[i].exp_res);
        if (e !== dir_rows[i].exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: model %h, table %h", i, e, dir_rows[i].exp_res);
        end
        send_pkt_noexp(dir_rows[i].pkt);
      end else begin
        send_pkt(dir_rows[i].pkt);
      end
    end

    // long receiver hold-off that stalls the sender while it fills the store
    long_hold = 1'b1;
    base = exp_next;
    for (int i = 0; i < 40; i++) send_pkt(mk_pkt(base + 64'($urandom_range(1, 60))));
    send_pkt(mk_pkt(base));

    // short burst near the next expected sequence
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
    for (int i = 0; i < 6; i++) send_pkt(mk_pkt(exp_next + 64'($urandom_range(0, 3))));

    for (int n = 0; n < N_RANDOM; n++) begin
      dice = $urandom_range(0, 99);
      if (dice < 75) p = mk_pkt(exp_next + 64'($urandom_range(0, 12)));
      else if (dice < 85) p = mk_pkt(exp_next - 64'($urandom_range(1, 20)));
      else if (dice < 95) p = mk_pkt({$urandom, $urandom});
      else p = mk_pkt(exp_next + 64'($urandom_range(0, 40)));
      send_pkt(p);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold && hold_cycles == 0) begin
        out_ready <= 1'b0;
        while (hold_cycles < 400) begin
          @(negedge clk);
          hold_cycles++;
        end
      end
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %h", out_data);
        end else if (out_data !== pending_results[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h, actual %h", pending_results[0], out_data);
          void'(pending_results.pop_front());
        end else begin
          void'(pending_results.pop_front());
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (stim_done && pending_results.size() == 0) begin
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0 && !out_valid)
          $display("Testbench completed without errors");
        else
          $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
